// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

  // Default number of queue slots
  localparam int unsigned DefDepth = 8;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned CountW = 4;

  // Command codes
  typedef enum logic {
    CmdEnq = 1'b0,
    CmdDeq = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // One slot of the queue
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
  } ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell #(
  parameter bit First = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::ctrl_t  ctrl_i,
  input  spq_pkg::entry_t left_i,     // neighbor closer to the front
  input  logic            left_ins_i, // neighbor is at or behind insert point
  input  spq_pkg::entry_t right_i,    // neighbor closer to the tail
  output logic            ins_o,
  output spq_pkg::entry_t entry_o
);

  spq_pkg::entry_t           entry_d;
  logic [spq_pkg::DataW-1:0] data_q;
  logic [spq_pkg::PrioW-1:0] prio_q;
  logic                      valid_q;
  logic                      take_left;

  // Insert point: first slot that is empty or holds a larger priority
  assign ins_o     = !valid_q || (prio_q > ctrl_i.prio);
  assign take_left = !First && left_ins_i;

  always_comb begin
    entry_d.valid = valid_q;
    entry_d.data  = data_q;
    entry_d.prio  = prio_q;
    if (ctrl_i.enq) begin
      if (ins_o) begin
        if (take_left) begin
          entry_d = left_i;
        end else begin
          entry_d.data = ctrl_i.data;
          entry_d.prio = ctrl_i.prio;
        end
      end
      // queue grows by one at the tail
      entry_d.valid = valid_q || First || left_i.valid;
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    data_q <= entry_d.data;
    prio_q <= entry_d.prio;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_comb begin
    entry_o.valid = valid_q;
    entry_o.data  = data_q;
    entry_o.prio  = prio_q;
  end

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result appears on valid_o in the cycle after start_i is taken.
// Throughput: one operation per cycle; every cell compares and shifts at once,
// so busy_o never rises. The receiver cannot stall the result beat.
// Reset clears the count and all slot valid bits; slot payload is not reset.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DefDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             command_i,
  input  logic signed [spq_pkg::DataW-1:0] data_in_i,
  input  logic        [spq_pkg::PrioW-1:0] priority_in_i,
  output logic                             valid_o,
  output logic signed [spq_pkg::DataW-1:0] data_out_o,
  output logic        [1:0]                status_o,
  output logic        [spq_pkg::CountW-1:0] count_out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  spq_pkg::entry_t                cells [DEPTH];
  logic            [DEPTH-1:0]    ins;
  spq_pkg::ctrl_t                 ctrl;
  spq_pkg::entry_t                tail;

  logic                           full, empty, is_deq;
  logic [CntW-1:0]                count_d, count_q;
  logic                           valid_d, valid_q;
  logic [spq_pkg::DataW-1:0]      dout_d, dout_q;
  spq_pkg::status_e               status_d, status_q;
  logic [CntW+spq_pkg::CountW-1:0] count_ext;

  assign busy_o = 1'b0;
  assign full   = cells[DEPTH-1].valid;
  assign empty  = !cells[0].valid;
  assign is_deq = (spq_pkg::cmd_e'(command_i) == spq_pkg::CmdDeq);

  // Operation broadcast, gated on full and empty
  assign ctrl.enq  = start_i && !is_deq && !full;
  assign ctrl.deq  = start_i && is_deq && !empty;
  assign ctrl.data = data_in_i;
  assign ctrl.prio = priority_in_i;

  // Empty slot shifted into the tail on dequeue
  assign tail = '0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_ins;
    if (i == 0) begin : g_head
      assign left_e   = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_e   = cells[i-1];
      assign left_ins = ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = tail;
    end else begin : g_body
      assign right_e = cells[i+1];
    end
    spq_cell #(
      .First (i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (left_e),
      .left_ins_i (left_ins),
      .right_i    (right_e),
      .ins_o      (ins[i]),
      .entry_o    (cells[i])
    );
  end

  // Result beat
  always_comb begin
    count_d  = count_q;
    valid_d  = start_i;
    dout_d   = '0;
    status_d = spq_pkg::StOk;
    if (start_i) begin
      if (is_deq) begin
        if (empty) begin
          status_d = spq_pkg::StEmpty;
          dout_d   = '1;
        end else begin
          dout_d  = cells[0].data;
          count_d = count_q - CntW'(1);
        end
      end else begin
        if (full) begin
          status_d = spq_pkg::StFull;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dout_q   <= dout_d;
    status_q <= status_d;
  end

  assign count_ext   = {{spq_pkg::CountW{1'b0}}, count_q};
  assign valid_o     = valid_q;
  assign data_out_o  = dout_q;
  assign status_o    = status_q;
  assign count_out_o = count_ext[spq_pkg::CountW-1:0];

endmodule

// ===== dv/tb_sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;

  localparam int unsigned Depth = spq_pkg::DefDepth;

  // Expected content of one result beat
  typedef struct {
    logic signed [spq_pkg::DataW-1:0]  data;
    spq_pkg::status_e                  status;
    logic        [spq_pkg::CountW-1:0] count;
  } pq_beat_t;

  // Shadow copy of the sorted queue plus the list of beats still to come
  class pq_scoreboard;
    logic signed [spq_pkg::DataW-1:0] slot_data[Depth];
    logic        [spq_pkg::PrioW-1:0] slot_prio[Depth];
    int unsigned                      held;
    pq_beat_t                         beats_due[$];
    int unsigned                      mismatches;
    int unsigned                      n_enq, n_deq, n_full, n_empty, n_beats;

    function new();
      held = 0;
      mismatches = 0;
      n_enq = 0; n_deq = 0; n_full = 0; n_empty = 0; n_beats = 0;
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    // Apply an accepted operation to the shadow queue and queue its result
    function void note_op(spq_pkg::cmd_e cmd, logic signed [spq_pkg::DataW-1:0] data,
                          logic [spq_pkg::PrioW-1:0] prio);
      pq_beat_t    exp_beat;
      int unsigned pos;
      exp_beat.data   = '0;
      exp_beat.status = spq_pkg::StOk;
      if (cmd == spq_pkg::CmdEnq) begin
        n_enq++;
        if (held >= Depth) begin
          exp_beat.status = spq_pkg::StFull;
          n_full++;
        end else begin
          // walk back past every entry with a strictly larger priority
          pos = held;
          while (pos > 0 && slot_prio[pos-1] > prio) begin
            slot_data[pos] = slot_data[pos-1];
            slot_prio[pos] = slot_prio[pos-1];
            pos--;
          end
          slot_data[pos] = data;
          slot_prio[pos] = prio;
          held++;
        end
      end else begin
        n_deq++;
        if (held == 0) begin
          exp_beat.status = spq_pkg::StEmpty;
          exp_beat.data   = '1;
          n_empty++;
        end else begin
          exp_beat.data = slot_data[0];
          for (int unsigned k = 1; k < held; k++) begin
            slot_data[k-1] = slot_data[k];
            slot_prio[k-1] = slot_prio[k];
          end
          held--;
        end
      end
      exp_beat.count = spq_pkg::CountW'(held);
      beats_due.push_back(exp_beat);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_beat(logic signed [spq_pkg::DataW-1:0] data, logic [1:0] status,
                             logic [spq_pkg::CountW-1:0] count);
      pq_beat_t exp_beat;
      n_beats++;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: data=%0d status=%0d count=%0d",
                   $time, data, status, count);
        return;
      end
      exp_beat = beats_due.pop_front();
      if (data !== exp_beat.data || status !== exp_beat.status ||
          count !== exp_beat.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: exp data=%0d status=%0d count=%0d, %s%0d %s%0d %s%0d",
                   $time, exp_beat.data, exp_beat.status, exp_beat.count,
                   "got data=", data, "status=", status, "count=", count);
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic                             command_i = spq_pkg::CmdEnq;
  logic signed [spq_pkg::DataW-1:0] data_in_i = '0;
  logic [spq_pkg::PrioW-1:0]        priority_in_i = '0;
  logic                             valid_o;
  logic signed [spq_pkg::DataW-1:0] data_out_o;
  logic [1:0]                       status_o;
  logic [spq_pkg::CountW-1:0]       count_out_o;

  pq_scoreboard sb = new();

  sorted_priority_queue_top #(
    .DEPTH (Depth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .data_in_i     (data_in_i),
    .priority_in_i (priority_in_i),
    .valid_o       (valid_o),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .count_out_o   (count_out_o)
  );

  always #2 clk_i = ~clk_i;

  // Monitor: note accepted beats, then check result beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_op(spq_pkg::cmd_e'(command_i), data_in_i, priority_in_i);
      if (valid_o)
        sb.check_beat(data_out_o, status_o, count_out_o);
    end
  end

  // Present one operation and hold it until taken
  task automatic send_op(input spq_pkg::cmd_e cmd,
                         input logic signed [spq_pkg::DataW-1:0] data,
                         input logic [spq_pkg::PrioW-1:0] prio);
    start_i       <= 1'b1;
    command_i     <= cmd;
    data_in_i     <= data;
    priority_in_i <= prio;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Hold off until every expected beat has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Random gap on the sender side: each cycle idles with about a third chance
  task automatic maybe_gap(input bit allow);
    if (allow) begin
      while ($urandom_range(99) < 32) begin
        start_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned                      enq_pct;
    int unsigned                      sel;
    logic signed [spq_pkg::DataW-1:0] rnd_data;
    logic [spq_pkg::PrioW-1:0]        rnd_prio;
    spq_pkg::cmd_e                    rnd_cmd;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty dequeue, extremes, ties, fill, overflow, drain
    send_op(spq_pkg::CmdDeq, 32'sd7, 8'd3);
    send_op(spq_pkg::CmdEnq, 32'sh7fffffff, 8'd255);
    send_op(spq_pkg::CmdEnq, 32'sh80000000, 8'd0);
    send_op(spq_pkg::CmdEnq, 32'sd0, 8'd128);
    send_op(spq_pkg::CmdEnq, -32'sd1, 8'd128);
    maybe_gap(1'b1);
    send_op(spq_pkg::CmdEnq, 32'sd5, 8'd128);
    send_op(spq_pkg::CmdEnq, 32'sd6, 8'd0);
    send_op(spq_pkg::CmdEnq, 32'sd7, 8'd255);
    send_op(spq_pkg::CmdEnq, 32'sd8, 8'd1);
    send_op(spq_pkg::CmdEnq, 32'sd9, 8'd0);
    send_op(spq_pkg::CmdEnq, 32'sd10, 8'd255);
    repeat (Depth) begin
      send_op(spq_pkg::CmdDeq, $urandom(), 8'($urandom()));
      maybe_gap(1'b1);
    end
    send_op(spq_pkg::CmdDeq, 32'sd0, 8'd0);
    send_op(spq_pkg::CmdEnq, 32'sh5a5a5a5a, 8'haa);
    send_op(spq_pkg::CmdDeq, 32'sha5a5a5a5, 8'h55);
    wait_drained();

    // Random: phases with shifting enqueue bias so the queue swings
    // between empty and full; frequent priority ties
    enq_pct = 50;
    for (int i = 0; i < 900; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(3))
          0: enq_pct = 25;
          1: enq_pct = 45;
          2: enq_pct = 60;
          default: enq_pct = 85;
        endcase
      end
      rnd_cmd = ($urandom_range(99) < enq_pct) ? spq_pkg::CmdEnq : spq_pkg::CmdDeq;
      sel = $urandom_range(99);
      if (sel < 35)      rnd_prio = 8'($urandom_range(3));
      else if (sel < 45) rnd_prio = $urandom_range(1) ? 8'd255 : 8'd0;
      else               rnd_prio = 8'($urandom());
      sel = $urandom_range(99);
      if (sel < 5)       rnd_data = 32'sh7fffffff;
      else if (sel < 10) rnd_data = 32'sh80000000;
      else if (sel < 13) rnd_data = -32'sd1;
      else               rnd_data = $urandom();
      send_op(rnd_cmd, rnd_data, rnd_prio);
      // back-to-back stretch with no sender gaps
      maybe_gap(!(i >= 200 && i < 400));
      if (i == 450) wait_drained();
    end

    wait_drained();
    repeat (5) @(negedge clk_i);

    $display("Covered %0d enqueues (%0d refused on full) and %0d dequeues (%0d on empty),",
             sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
    $display("%0d result beats checked, %0d mismatches.", sb.n_beats, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timeout with %0d result beats outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
dv/tb_sorted_priority_queue_top.sv
